/* hdl/dab_pkg.sv */
`default_nettype none

package dab_pkg;

    localparam int LIMB_W       = 32;
    localparam int MUL_LAT      = 4;
    localparam int BLEN_LAT     = 2;
    localparam int RAD_W        = 126;
    localparam int ROOT_BITS    = 63;
    localparam int CORDIC_STEPS = 62;
    localparam int NORM_TOP     = 60;
    localparam int FX_W         = 7;
    localparam logic [63:0] TWO_OVER_PI = 64'hA2F9836E4E441529;

    function automatic logic [3:0] bitlen8(input logic [7:0] v);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                r = 4'(i + 1);
            end
        end
        return r;
    endfunction

    // atan(2^-k) as a 64-bit binary angle, evaluated at elaboration
    function automatic logic [63:0] step_angle(input int k);
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] rem;
        logic [127:0] prod;
        int ex;
        int dv;
        acc = '0;
        if (k == 0)
        begin
            return 64'h1 << 61;
        end
        for (int m = 0; m < 64; m++)
        begin
            ex = k * (2 * m + 1);
            if (ex <= 64)
            begin
                dv = 2 * m + 1;
                term = '0;
                rem = '0;
                for (int b = 63; b >= 0; b--)
                begin
                    rem = {rem[62:0], (b == 64 - ex)};
                    if (rem >= 64'(dv))
                    begin
                        rem = rem - 64'(dv);
                        term[b] = 1'b1;
                    end
                end
                if (m[0])
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
        end
        prod = {64'b0, acc} * {64'b0, TWO_OVER_PI};
        return {2'b0, prod[127:66]};
    endfunction

endpackage

`default_nettype wire

/* hdl/dab_dly.sv */
`default_nettype none

module dab_dly #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [D];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < D; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[D-1];

endmodule

`default_nettype wire

/* hdl/dab_mul.sv */
`default_nettype none

module dab_mul #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);

    localparam int LW = dab_pkg::LIMB_W;
    localparam int NA = (WA + LW - 1) / LW;
    localparam int NB = (WB + LW - 1) / LW;
    localparam int PW = (NA + NB) * LW;

    logic [WA-1:0]    am;
    logic [WB-1:0]    bm;
    logic [NA*LW-1:0] ma_reg;
    logic [NB*LW-1:0] mb_reg;
    logic [2:0]       neg_reg;
    logic [2*LW-1:0]  pp_reg [NA][NB];
    logic [PW-1:0]    row_next [NA];
    logic [PW-1:0]    row_reg [NA];
    logic [PW-1:0]    tot;
    logic [WA+WB-1:0] p_reg;

    always_comb
    begin
        am = a[WA-1] ? WA'(-a) : WA'(a);
        bm = b[WB-1] ? WB'(-b) : WB'(b);
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (PW'(pp_reg[i][j]) << (j * LW));
            end
        end
        tot = '0;
        for (int i = 0; i < NA; i++)
        begin
            tot = tot + (row_reg[i] << (i * LW));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg <= (NA*LW)'(am);
            mb_reg <= (NB*LW)'(bm);
            neg_reg <= {neg_reg[1:0], a[WA-1] ^ b[WB-1]};
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= (2*LW)'(ma_reg[i*LW +: LW]) * (2*LW)'(mb_reg[j*LW +: LW]);
                end
                row_reg[i] <= row_next[i];
            end
            p_reg <= neg_reg[2] ? (WA+WB)'(-tot) : (WA+WB)'(tot);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* hdl/dab_blen.sv */
`default_nettype none

module dab_blen #(
    parameter int W = 64
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [W-1:0]           d,
    output logic [$clog2(W+1)-1:0] len
);

    localparam int NG = (W + 7) / 8;
    localparam int BW = $clog2(W + 1);

    logic [NG*8-1:0] pad;
    logic [3:0]      gl_reg [NG];
    logic [BW-1:0]   len_next;
    logic [BW-1:0]   len_reg;

    always_comb
    begin
        pad = (NG*8)'(d);
        len_next = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (gl_reg[g] != 4'd0)
            begin
                len_next = BW'(g * 8 + int'(gl_reg[g]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < NG; g++)
            begin
                gl_reg[g] <= dab_pkg::bitlen8(pad[g*8 +: 8]);
            end
            len_reg <= len_next;
        end
    end

    assign len = len_reg;

endmodule

`default_nettype wire

/* hdl/dab_sqrt.sv */
`default_nettype none

module dab_sqrt (
    input  logic                           clk,
    input  logic                           en,
    input  logic [dab_pkg::RAD_W-1:0]      rad,
    output logic [dab_pkg::ROOT_BITS-1:0]  root
);

    localparam int RW = dab_pkg::RAD_W;
    localparam int NB = dab_pkg::ROOT_BITS;

    logic [RW-1:0] rem_reg  [NB];
    logic [NB-1:0] root_reg [NB];

    for (genvar s = 0; s < NB; s++)
    begin : g_bit
        localparam int B = NB - 1 - s;
        logic [RW-1:0] rem_in;
        logic [NB-1:0] root_in;
        logic [RW-1:0] trial;

        if (s == 0)
        begin : g_first
            assign rem_in  = rad;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        assign trial = (RW'(root_in) << (B + 1)) | (RW'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    rem_reg[s]  <= rem_in - trial;
                    root_reg[s] <= root_in | (NB'(1) << B);
                end
                else
                begin
                    rem_reg[s]  <= rem_in;
                    root_reg[s] <= root_in;
                end
            end
        end
    end

    assign root = root_reg[NB-1];

endmodule

`default_nettype wire

/* hdl/dab_cordic.sv */
`default_nettype none

module dab_cordic (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] x,
    input  logic [63:0] y,
    input  logic [63:0] z,
    output logic [63:0] zo
);

    localparam int NS = dab_pkg::CORDIC_STEPS;

    logic [63:0] x_reg [NS];
    logic [63:0] y_reg [NS];
    logic [63:0] z_reg [NS];

    for (genvar q = 0; q < NS; q++)
    begin : g_step
        localparam logic [63:0] ANG = dab_pkg::step_angle(q);
        logic [63:0] xi;
        logic [63:0] yi;
        logic [63:0] zi;
        logic [63:0] dx;
        logic [63:0] dy;

        if (q == 0)
        begin : g_first
            assign xi = x;
            assign yi = y;
            assign zi = z;
        end
        else
        begin : g_next
            assign xi = x_reg[q-1];
            assign yi = y_reg[q-1];
            assign zi = z_reg[q-1];
        end

        assign dx = 64'($signed(yi) >>> q);
        assign dy = 64'($signed(xi) >>> q);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!yi[63])
                begin
                    x_reg[q] <= xi + dx;
                    y_reg[q] <= yi - dy;
                    z_reg[q] <= zi + ANG;
                end
                else
                begin
                    x_reg[q] <= xi - dx;
                    y_reg[q] <= yi + dy;
                    z_reg[q] <= zi - ANG;
                end
            end
        end
    end

    assign zo = z_reg[NS-1];

endmodule

`default_nettype wire

/* hdl/dihedral_angle_between_triangles.sv */
// Pipeline: an accepted request passes the cross-product and dot-product multipliers,
//   a 63-step square root and a 62-step CORDIC before its result is presented.
// Throughput: one request per cycle; a stalled result freezes the whole pipeline.
// Reset: rst_n asynchronous, active low, clears the valid bits; data registers keep
//   whatever they hold.
`default_nettype none

module dihedral_angle_between_triangles #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic signed [COORD_WIDTH-1:0] p1_x,
    input  logic signed [COORD_WIDTH-1:0] p1_y,
    input  logic signed [COORD_WIDTH-1:0] p1_z,
    input  logic signed [COORD_WIDTH-1:0] p2_x,
    input  logic signed [COORD_WIDTH-1:0] p2_y,
    input  logic signed [COORD_WIDTH-1:0] p2_z,
    input  logic signed [COORD_WIDTH-1:0] p3_x,
    input  logic signed [COORD_WIDTH-1:0] p3_y,
    input  logic signed [COORD_WIDTH-1:0] p3_z,
    input  logic signed [COORD_WIDTH-1:0] p4_x,
    input  logic signed [COORD_WIDTH-1:0] p4_y,
    input  logic signed [COORD_WIDTH-1:0] p4_z,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [ANGLE_WIDTH-1:0]        dihedral_angle,
    output logic                          degenerate
);

    localparam int ML  = dab_pkg::MUL_LAT;
    localparam int BL  = dab_pkg::BLEN_LAT;
    localparam int RB  = dab_pkg::ROOT_BITS;
    localparam int RW  = dab_pkg::RAD_W;
    localparam int FW  = dab_pkg::FX_W;
    localparam int DW  = COORD_WIDTH + 1;
    localparam int NPW = 2 * DW;
    localparam int NW  = NPW + 1;
    localparam int CPW = 2 * NW;
    localparam int CNW = CPW + 2;
    localparam int SPW = NW + DW;
    localparam int SDW = SPW + 2;
    localparam int EPW = 2 * DW;
    localparam int EW  = EPW + 2;
    localparam int WX  = CNW + RB;
    localparam int WY  = RB + SDW;
    localparam int WN  = (WX > WY) ? WX : WY;
    localparam int BE  = $clog2(EW + 1);
    localparam int BX  = $clog2(WX + 1);
    localparam int BY  = $clog2(WY + 1);
    localparam int BN  = $clog2(WN + 1);
    localparam int LAT = 1 + ML + 1 + ML + 1 + BL + 1 + RB + ML + BL + 1
                         + dab_pkg::CORDIC_STEPS + 1;

    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en        = !(vld_reg[LAT-1] && rsp_stall);
    assign req_stall = !en;
    assign rsp_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], req_valid};
        end
    end

    // differences against the shared edge start
    logic signed [COORD_WIDTH-1:0] pt [4][3];
    logic signed [DW-1:0] leg1_reg [3];
    logic signed [DW-1:0] edge_reg [3];
    logic signed [DW-1:0] leg4_reg [3];

    assign pt[0] = '{p1_x, p1_y, p1_z};
    assign pt[1] = '{p2_x, p2_y, p2_z};
    assign pt[2] = '{p3_x, p3_y, p3_z};
    assign pt[3] = '{p4_x, p4_y, p4_z};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                leg1_reg[ax] <= DW'(pt[0][ax]) - DW'(pt[1][ax]);
                edge_reg[ax] <= DW'(pt[2][ax]) - DW'(pt[1][ax]);
                leg4_reg[ax] <= DW'(pt[3][ax]) - DW'(pt[1][ax]);
            end
        end
    end

    // normals
    logic signed [NPW-1:0] pa1 [3];
    logic signed [NPW-1:0] pb1 [3];
    logic signed [NPW-1:0] pa2 [3];
    logic signed [NPW-1:0] pb2 [3];
    logic signed [NW-1:0]  n1_reg [3];
    logic signed [NW-1:0]  n2_reg [3];

    for (genvar ax = 0; ax < 3; ax++)
    begin : g_cross
        localparam int I1 = (ax + 1) % 3;
        localparam int I2 = (ax + 2) % 3;
        dab_mul #(.WA(DW), .WB(DW)) u_m1a (.clk(clk), .en(en),
            .a(leg1_reg[I1]), .b(edge_reg[I2]), .p(pa1[ax]));
        dab_mul #(.WA(DW), .WB(DW)) u_m1b (.clk(clk), .en(en),
            .a(leg1_reg[I2]), .b(edge_reg[I1]), .p(pb1[ax]));
        dab_mul #(.WA(DW), .WB(DW)) u_m2a (.clk(clk), .en(en),
            .a(edge_reg[I1]), .b(leg4_reg[I2]), .p(pa2[ax]));
        dab_mul #(.WA(DW), .WB(DW)) u_m2b (.clk(clk), .en(en),
            .a(edge_reg[I2]), .b(leg4_reg[I1]), .p(pb2[ax]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                n1_reg[ax] <= NW'(pa1[ax]) - NW'(pb1[ax]);
                n2_reg[ax] <= NW'(pa2[ax]) - NW'(pb2[ax]);
            end
        end
    end

    logic [6*DW-1:0] el_d;
    logic signed [DW-1:0] edge_d [3];
    logic signed [DW-1:0] leg4_d [3];

    dab_dly #(.W(6*DW), .D(ML+1)) u_dly_el (.clk(clk), .en(en),
        .d({edge_reg[0], edge_reg[1], edge_reg[2], leg4_reg[0], leg4_reg[1], leg4_reg[2]}),
        .q(el_d));

    assign edge_d[0] = el_d[6*DW-1 -: DW];
    assign edge_d[1] = el_d[5*DW-1 -: DW];
    assign edge_d[2] = el_d[4*DW-1 -: DW];
    assign leg4_d[0] = el_d[3*DW-1 -: DW];
    assign leg4_d[1] = el_d[2*DW-1 -: DW];
    assign leg4_d[2] = el_d[DW-1 -: DW];

    logic deg_n;
    logic deg_s11;

    assign deg_n = ((n1_reg[0] == '0) && (n1_reg[1] == '0) && (n1_reg[2] == '0))
                || ((n2_reg[0] == '0) && (n2_reg[1] == '0) && (n2_reg[2] == '0));

    dab_dly #(.W(1), .D(ML)) u_dly_deg (.clk(clk), .en(en), .d(deg_n), .q(deg_s11));

    // dot products
    logic signed [CPW-1:0] cp [3];
    logic signed [SPW-1:0] sp [3];
    logic signed [EPW-1:0] ep [3];
    logic signed [CNW-1:0] cos_reg;
    logic signed [SDW-1:0] side_reg;
    logic signed [EW-1:0]  elen_reg;
    logic                  deg_reg;

    for (genvar ax = 0; ax < 3; ax++)
    begin : g_dot
        dab_mul #(.WA(NW), .WB(NW)) u_mc (.clk(clk), .en(en),
            .a(n1_reg[ax]), .b(n2_reg[ax]), .p(cp[ax]));
        dab_mul #(.WA(NW), .WB(DW)) u_ms (.clk(clk), .en(en),
            .a(n1_reg[ax]), .b(leg4_d[ax]), .p(sp[ax]));
        dab_mul #(.WA(DW), .WB(DW)) u_me (.clk(clk), .en(en),
            .a(edge_d[ax]), .b(edge_d[ax]), .p(ep[ax]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg  <= CNW'(cp[0]) + CNW'(cp[1]) + CNW'(cp[2]);
            side_reg <= SDW'(sp[0]) + SDW'(sp[1]) + SDW'(sp[2]);
            elen_reg <= EW'(ep[0]) + EW'(ep[1]) + EW'(ep[2]);
            deg_reg  <= deg_s11;
        end
    end

    // scale the edge length for the square root
    logic [BE-1:0] elen_bl;
    logic [CNW+SDW+EW:0] s13_d;
    logic signed [CNW-1:0] cos_d;
    logic signed [SDW-1:0] side_d;
    logic [EW-1:0] elen_d;
    logic deg_d13;

    dab_blen #(.W(EW)) u_blen_e (.clk(clk), .en(en), .d(elen_reg), .len(elen_bl));
    dab_dly #(.W(CNW+SDW+EW+1), .D(BL)) u_dly_s13 (.clk(clk), .en(en),
        .d({cos_reg, side_reg, elen_reg, deg_reg}), .q(s13_d));

    assign cos_d   = s13_d[CNW+SDW+EW -: CNW];
    assign side_d  = s13_d[SDW+EW -: SDW];
    assign elen_d  = s13_d[EW -: EW];
    assign deg_d13 = s13_d[0];

    logic [FW-1:0]  fx;
    logic [CNW-1:0] cabs;
    logic [SDW-1:0] sabs;
    logic [RW-1:0]  rad_reg;
    logic [WX-1:0]  xmag_reg;
    logic [SDW-1:0] sabs_reg;
    logic [2:0]     flg_reg;

    assign fx   = FW'((RW - int'(elen_bl)) >> 1);
    assign cabs = cos_d[CNW-1] ? CNW'(-cos_d) : CNW'(cos_d);
    assign sabs = side_d[SDW-1] ? SDW'(-side_d) : SDW'(side_d);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= RW'(elen_d) << {fx, 1'b0};
            xmag_reg <= WX'(cabs) << fx;
            sabs_reg <= sabs;
            flg_reg  <= {cos_d[CNW-1], side_d[SDW-1], deg_d13};
        end
    end

    // square root and vector length
    logic [RB-1:0] root;
    logic [WX+SDW+2:0] s77_d;
    logic [WX-1:0]  xmag_77;
    logic [SDW-1:0] sabs_77;
    logic [2:0]     flg_77;

    dab_sqrt u_sqrt (.clk(clk), .en(en), .rad(rad_reg), .root(root));
    dab_dly #(.W(WX+SDW+3), .D(RB)) u_dly_s77 (.clk(clk), .en(en),
        .d({xmag_reg, sabs_reg, flg_reg}), .q(s77_d));

    assign xmag_77 = s77_d[WX+SDW+2 -: WX];
    assign sabs_77 = s77_d[SDW+2 -: SDW];
    assign flg_77  = s77_d[2:0];

    logic signed [64+SDW:0] yprod;
    logic [WX+2:0] s81_d;

    dab_mul #(.WA(64), .WB(SDW+1)) u_my (.clk(clk), .en(en),
        .a({1'b0, root}), .b({1'b0, sabs_77}), .p(yprod));
    dab_dly #(.W(WX+3), .D(ML)) u_dly_s81 (.clk(clk), .en(en),
        .d({xmag_77, flg_77}), .q(s81_d));

    logic [WY-1:0] ymag;
    logic [WX-1:0] xmag_81;
    logic [BX-1:0] xbl;
    logic [BY-1:0] ybl;
    logic [WX+WY+2:0] s83_d;
    logic [WX-1:0] xmag_83;
    logic [WY-1:0] ymag_83;
    logic [2:0]    flg_83;

    assign ymag    = yprod[WY-1:0];
    assign xmag_81 = s81_d[WX+2 -: WX];

    dab_blen #(.W(WX)) u_blen_x (.clk(clk), .en(en), .d(xmag_81), .len(xbl));
    dab_blen #(.W(WY)) u_blen_y (.clk(clk), .en(en), .d(ymag), .len(ybl));
    dab_dly #(.W(WX+WY+3), .D(BL)) u_dly_s83 (.clk(clk), .en(en),
        .d({xmag_81, ymag, s81_d[2:0]}), .q(s83_d));

    assign xmag_83 = s83_d[WX+WY+2 -: WX];
    assign ymag_83 = s83_d[WY+2 -: WY];
    assign flg_83  = s83_d[2:0];

    // normalize to a common scale and fold the left half-plane
    logic [BN-1:0] top;
    logic [WN-1:0] xs;
    logic [WN-1:0] ys;
    logic [63:0]   cx_reg;
    logic [63:0]   cy_reg;
    logic [63:0]   z0_reg;
    logic [1:0]    flg_reg84;

    always_comb
    begin
        top = (BN'(xbl) > BN'(ybl)) ? BN'(xbl) : BN'(ybl);
        if (int'(top) <= dab_pkg::NORM_TOP)
        begin
            xs = WN'(xmag_83) << (dab_pkg::NORM_TOP - int'(top));
            ys = WN'(ymag_83) << (dab_pkg::NORM_TOP - int'(top));
        end
        else
        begin
            xs = WN'(xmag_83) >> (int'(top) - dab_pkg::NORM_TOP);
            ys = WN'(ymag_83) >> (int'(top) - dab_pkg::NORM_TOP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (flg_83[2])
            begin
                cx_reg <= ys[63:0];
                cy_reg <= xs[63:0];
                z0_reg <= 64'h1 << 62;
            end
            else
            begin
                cx_reg <= xs[63:0];
                cy_reg <= ys[63:0];
                z0_reg <= '0;
            end
            flg_reg84 <= flg_83[1:0];
        end
    end

    logic [63:0] zf;
    logic [1:0]  flg_end;
    logic [63:0] phi;
    logic [63:0] phi_rnd;
    logic [ANGLE_WIDTH-1:0] ang_reg;
    logic                   deg_out_reg;

    dab_cordic u_cordic (.clk(clk), .en(en), .x(cx_reg), .y(cy_reg), .z(z0_reg), .zo(zf));
    dab_dly #(.W(2), .D(dab_pkg::CORDIC_STEPS)) u_dly_end (.clk(clk), .en(en),
        .d(flg_reg84), .q(flg_end));

    assign phi     = flg_end[1] ? (64'h1 << 63) + zf : (64'h1 << 63) - zf;
    assign phi_rnd = phi + (64'h1 << (63 - ANGLE_WIDTH));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg     <= flg_end[0] ? '0 : phi_rnd[63 -: ANGLE_WIDTH];
            deg_out_reg <= flg_end[0];
        end
    end

    assign dihedral_angle = ang_reg;
    assign degenerate     = deg_out_reg;

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && degenerate |-> dihedral_angle == '0)
        else $error("degenerate result with nonzero angle");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(vld_reg))
        else $error("pipeline moved while result stalled");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> vld_reg[0])
        else $error("accepted request not tracked");

endmodule

`default_nettype wire
